/* rtl/mkt_pkg.sv */
package mkt_pkg;

  // Token kinds
  localparam logic [4:0] KIND_ILLEGAL = 5'd0;
  localparam logic [4:0] KIND_EOF     = 5'd1;
  localparam logic [4:0] KIND_LT      = 5'd2;
  localparam logic [4:0] KIND_GT      = 5'd3;
  localparam logic [4:0] KIND_LBRACE  = 5'd4;
  localparam logic [4:0] KIND_RBRACE  = 5'd5;
  localparam logic [4:0] KIND_COLON   = 5'd6;
  localparam logic [4:0] KIND_COMMA   = 5'd7;
  localparam logic [4:0] KIND_SLASH   = 5'd8;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

  // Keyword table. Text is right-justified: the last letter sits in the low byte.
  localparam int KW_COUNT   = 19;
  localparam int KW_MAX_LEN = 9;

  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    "up", "down", "left", "right", "bold", "underline", "italic", "blink",
    "invert", "strike", "default", "black", "red", "green", "yellow", "blue",
    "magenta", "cyan", "white"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd4, 4'd4, 4'd5, 4'd4, 4'd9, 4'd6, 4'd5, 4'd6, 4'd6,
    4'd7, 4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd7, 4'd4, 4'd5
  };
  localparam logic [4:0] KW_KIND [KW_COUNT] = '{
    5'd9, 5'd10, 5'd11, 5'd12, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
    5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31
  };

  // Output queue depth; one byte may push two tokens.
  localparam int QUEUE_DEPTH = 4;

  // Letters held for matching, first letter at index 0.
  typedef logic [KW_MAX_LEN-1:0][7:0] kw_word_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] depth;
    logic        unbal;
    logic        last;
  } token_t;

  typedef struct packed {
    logic   v0;
    logic   v1;
    token_t t0;
    token_t t1;
  } push_t;

  // Parallel match of a word against every keyword.
  function automatic logic [4:0] kw_kind(input kw_word_t word, input logic [3:0] len);
    logic [4:0] kind;
    logic       eq;
    int         kl;
    kind = KIND_ILLEGAL;
    for (int k = 0; k < KW_COUNT; k++) begin
      kl = int'(KW_LEN[k]);
      eq = (KW_LEN[k] == len);
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (j < kl) begin
          if (word[j] != KW_TEXT[k][8*(kl-1-j) +: 8]) begin
            eq = 1'b0;
          end
        end
      end
      if (eq) begin
        kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

endpackage

/* rtl/mkt_if.sv */
interface mkt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface mkt_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] bracket_depth_out;
  logic        unbalanced_close;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output bracket_depth_out, output unbalanced_close,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input bracket_depth_out, input unbalanced_close,
                  input last_of_run, output ready);
endinterface

/* rtl/markup_keyword_tokenizer_core.sv */
// A byte accepted on the input channel is held in the input register, lexed once the
// output queue has room for two token words, and its token words are written to the queue,
// which offers them on the output channel. Throughput: one byte per cycle while each byte
// yields at most one token and the output channel is ready; the output queue drains one
// token word per cycle while the channel is ready, so a byte that yields two needs two pops.
// Reset (rst_n, synchronous, active low) clears position, depth, word length and the queue.
module markup_keyword_tokenizer_core
  import mkt_pkg::*;
#(
  parameter int IDENT_BUFFER = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  mkt_char_if.sink     in_chan,
  mkt_token_if.source  out_chan
);

  // The input register holds one byte. It is handed to the lexer as soon as the
  // output queue can take the worst case of two token words; the queue itself is
  // the result register, so the byte register refills in the same cycle.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       room;
  logic       advance;
  logic       pop;
  logic       head_valid;
  token_t     head;
  push_t      push;

  assign advance       = in_valid_r && room;
  assign in_chan.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.char_byte;
    end
  end

  // Lexer: letter gathering, keyword match, punctuation and bracket depth.
  mkt_lexer #(
    .IDENT_BUFFER (IDENT_BUFFER)
  ) u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (advance),
    .char_byte (in_byte_r),
    .push      (push)
  );

  // Output queue: takes up to two token words per cycle, in order, and
  // presents one at a time to the output channel.
  mkt_token_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  assign pop = head_valid && out_chan.ready;

  assign out_chan.valid             = head_valid;
  assign out_chan.token_kind        = head.kind;
  assign out_chan.token_start       = head.start;
  assign out_chan.bracket_depth_out = head.depth;
  assign out_chan.unbalanced_close  = head.unbal;
  assign out_chan.last_of_run       = head.last;

endmodule

/* rtl/mkt_lexer.sv */
module mkt_lexer
  import mkt_pkg::*;
#(
  parameter int IDENT_BUFFER = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [7:0] char_byte,
  output push_t      push
);

  localparam int LW = $clog2(IDENT_BUFFER);
  localparam logic [LW-1:0] MAX_WORD = LW'(IDENT_BUFFER - 1);

  kw_word_t      chars_r, chars_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [15:0]   start_r, start_nxt;
  logic [15:0]   pos_r, pos_nxt;
  logic [15:0]   depth_r, depth_nxt;

  logic       is_letter, is_space;
  logic [4:0] own_kind;
  logic       word_emit, own_emit, flag;
  token_t     word_tok, own_tok;

  always_comb begin
    is_letter = ((char_byte >= CH_UPPER_A) && (char_byte <= CH_UPPER_Z)) ||
                ((char_byte >= CH_LOWER_A) && (char_byte <= CH_LOWER_Z));
    is_space  = 1'b0;
    own_kind  = KIND_ILLEGAL;
    unique case (char_byte)
      CH_LT:     own_kind = KIND_LT;
      CH_GT:     own_kind = KIND_GT;
      CH_LBRACE: own_kind = KIND_LBRACE;
      CH_RBRACE: own_kind = KIND_RBRACE;
      CH_COLON:  own_kind = KIND_COLON;
      CH_COMMA:  own_kind = KIND_COMMA;
      CH_SLASH:  own_kind = KIND_SLASH;
      CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: is_space = 1'b1;
      default:   own_kind = KIND_ILLEGAL;
    endcase
  end

  always_comb begin
    chars_nxt = chars_r;
    len_nxt   = len_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    depth_nxt = depth_r;
    word_emit = 1'b0;
    own_emit  = 1'b0;
    flag      = 1'b0;

    word_tok.kind  = (int'(len_r) <= KW_MAX_LEN) ? kw_kind(chars_r, 4'(len_r))
                                                  : KIND_ILLEGAL;
    word_tok.start = start_r;
    word_tok.depth = depth_r;
    word_tok.unbal = 1'b0;
    word_tok.last  = 1'b0;

    own_tok.kind  = own_kind;
    own_tok.start = pos_r;
    own_tok.depth = depth_r;
    own_tok.unbal = 1'b0;
    own_tok.last  = 1'b1;

    if (go) begin
      if (char_byte == CH_NUL) begin
        word_emit    = (len_r != '0);
        own_emit     = 1'b1;
        own_tok.kind = KIND_EOF;
        len_nxt      = '0;
        start_nxt    = '0;
        pos_nxt      = '0;
        depth_nxt    = '0;
      end else if (is_letter) begin
        pos_nxt = pos_r + 16'd1;
        if (len_r == MAX_WORD) begin
          // Word full: send it and start afresh with this letter.
          word_emit    = 1'b1;
          start_nxt    = pos_r;
          chars_nxt[0] = char_byte;
          len_nxt      = LW'(1);
        end else begin
          if (len_r == '0) begin
            start_nxt = pos_r;
          end
          if (int'(len_r) < KW_MAX_LEN) begin
            chars_nxt[4'(len_r)] = char_byte;
          end
          len_nxt = len_r + LW'(1);
        end
      end else begin
        pos_nxt   = pos_r + 16'd1;
        word_emit = (len_r != '0);
        len_nxt   = '0;
        own_emit  = !is_space;
        if (!is_space && ((own_kind == KIND_LT) || (own_kind == KIND_LBRACE))) begin
          if (depth_r != DEPTH_MAX) begin
            depth_nxt = depth_r + 16'd1;
          end
        end else if (!is_space && ((own_kind == KIND_GT) || (own_kind == KIND_RBRACE))) begin
          if (depth_r == '0) begin
            flag = 1'b1;
          end else begin
            depth_nxt = depth_r - 16'd1;
          end
        end
        own_tok.depth = depth_nxt;
        own_tok.unbal = flag;
      end
    end

    word_tok.last = !own_emit;
    push.v0 = word_emit || own_emit;
    push.t0 = word_emit ? word_tok : own_tok;
    push.v1 = word_emit && own_emit;
    push.t1 = own_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      start_r <= '0;
      pos_r   <= '0;
      depth_r <= '0;
    end else begin
      len_r   <= len_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
  end

endmodule

/* rtl/mkt_token_fifo.sv */
module mkt_token_fifo
  import mkt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  input  logic   pop,
  output logic   room,
  output logic   head_valid,
  output token_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  token_t        mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Room for a full pair of tokens, regardless of a pop this cycle.
  assign room       = (int'(cnt_r) <= QUEUE_DEPTH - 2);
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + PW'(push.v0) + PW'(push.v1);
    rp_nxt  = rp_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(push.v0) + CW'(push.v1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wp_r] <= push.t0;
    end
    if (push.v1) begin
      mem_r[wp_r + PW'(1)] <= push.t1;
    end
  end

endmodule

/* tb/sv/markup_keyword_tokenizer_core_test.sv */
`timescale 1ns / 100ps

// Testbench for the keyword tokeniser. A byte stream is pushed into the input
// channel and every token word that leaves the block is checked, field by
// field, against a cycle-free software predictor of the lexer.
module markup_keyword_tokenizer_core_test;
  import mkt_pkg::*;

  localparam int IDENT_BUFFER = 32;
  localparam int MAX_LETTERS  = IDENT_BUFFER - 1;

  // The receiver's long hold-off, long enough to fill the output queue and
  // back the stall up onto the input channel.
  localparam int HOLD_CYCLES = 80;
  // Cycles with no handshake on either channel before the run is abandoned.
  // The worst honest quiet stretch is the hold-off above plus random stalling,
  // so this is many times over.
  localparam int QUIET_LIMIT = 2000;
  // Cycles allowed after the last expected token word, covering the
  // input register and the output queue with a good margin.
  localparam int END_SLACK   = 12;
  localparam int SHOW_LIMIT  = 40;
  // Angle-bracket opens in the final nest; a brace open follows them before the keyword.
  localparam int NEST_OPENS  = 20;

  // Keyword token kinds. The package names only the kinds up to the slash.
  localparam logic [4:0] KIND_UP        = 5'd9;
  localparam logic [4:0] KIND_DOWN      = 5'd10;
  localparam logic [4:0] KIND_LEFT      = 5'd11;
  localparam logic [4:0] KIND_RIGHT     = 5'd12;
  localparam logic [4:0] KIND_BOLD      = 5'd14;
  localparam logic [4:0] KIND_UNDERLINE = 5'd15;
  localparam logic [4:0] KIND_ITALIC    = 5'd16;
  localparam logic [4:0] KIND_BLINK     = 5'd17;
  localparam logic [4:0] KIND_INVERT    = 5'd18;
  localparam logic [4:0] KIND_STRIKE    = 5'd19;
  localparam logic [4:0] KIND_DEFAULT   = 5'd23;
  localparam logic [4:0] KIND_BLACK     = 5'd24;
  localparam logic [4:0] KIND_RED       = 5'd25;
  localparam logic [4:0] KIND_GREEN     = 5'd26;
  localparam logic [4:0] KIND_YELLOW    = 5'd27;
  localparam logic [4:0] KIND_BLUE      = 5'd28;
  localparam logic [4:0] KIND_MAGENTA   = 5'd29;
  localparam logic [4:0] KIND_CYAN      = 5'd30;
  localparam logic [4:0] KIND_WHITE     = 5'd31;

  logic clk;
  logic rst_n;

  mkt_char_if  char_ch();
  mkt_token_if tok_ch();

  markup_keyword_tokenizer_core #(.IDENT_BUFFER(IDENT_BUFFER)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (char_ch),
    .out_chan (tok_ch)
  );

  // Bytes waiting to be offered, and token words the predictor says must
  // come out, oldest first.
  logic [7:0] pending_bytes[$];
  token_t     tokens_due[$];
  token_t     step_tokens[$];

  // Predictor state: the pending identifier, its start, the running
  // character position and the bracket depth.
  logic [7:0]  letters[MAX_LETTERS];
  int unsigned letter_count;
  logic [15:0] letters_start;
  logic [15:0] char_pos;
  logic [15:0] depth;

  // Traffic shaping, requested by the stimulus process, and the watchdog's quiet count.
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int quiet;

  // Bookkeeping for the verdict and the closing summary.
  int          mismatches;
  int          queued_total;
  int          tokens_checked;
  int          bytes_taken;
  int          strings_ended;
  int          splits;
  int          unbal_closes;
  logic [15:0] peak_depth;

  string keywords[19] = '{
    "up", "down", "left", "right", "bold", "underline", "italic", "blink",
    "invert", "strike", "default", "black", "red", "green", "yellow", "blue",
    "magenta", "cyan", "white"
  };
  logic [7:0] punct[7]  = '{CH_LT, CH_GT, CH_LBRACE, CH_RBRACE, CH_COLON,
                            CH_COMMA, CH_SLASH};
  logic [7:0] blanks[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  int long_lengths[8]   = '{30, 31, 32, 33, 61, 62, 63, 70};

  // ------------------------------------------------------------------
  // Clock, reset and known values on every input from time zero.
  // ------------------------------------------------------------------
  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    char_ch.valid      = 1'b0;
    char_ch.char_byte  = 8'h00;
    tok_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_req           = 1'b0;
    hold_left          = 0;
    quiet              = 0;
    mismatches         = 0;
    queued_total       = 0;
    tokens_checked     = 0;
    bytes_taken        = 0;
    strings_ended      = 0;
    splits             = 0;
    unbal_closes       = 0;
    peak_depth         = '0;
    letter_count       = 0;
    letters_start      = '0;
    char_pos           = '0;
    depth              = '0;
    forever #10 clk = ~clk;
  end

  // Reset is held from time zero and then released for good.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ------------------------------------------------------------------
  // Predictor.
  // ------------------------------------------------------------------

  function automatic bit is_letter(input logic [7:0] ch);
    return (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
           (ch >= CH_LOWER_A && ch <= CH_LOWER_Z);
  endfunction

  // The pending letters are packed right-justified, last letter in the low
  // byte, so that a shorter word leaves zero bytes on top and the compare
  // against each keyword is exact in length as well as in content.
  function automatic logic [4:0] keyword_kind();
    logic [8*KW_MAX_LEN-1:0] packed_word;
    packed_word = '0;
    if (letter_count > KW_MAX_LEN) return KIND_ILLEGAL;
    for (int i = 0; i < letter_count; i++) begin
      packed_word = {packed_word[8*KW_MAX_LEN-9:0], letters[i]};
    end
    case (packed_word)
      "up":        return KIND_UP;
      "down":      return KIND_DOWN;
      "left":      return KIND_LEFT;
      "right":     return KIND_RIGHT;
      "bold":      return KIND_BOLD;
      "underline": return KIND_UNDERLINE;
      "italic":    return KIND_ITALIC;
      "blink":     return KIND_BLINK;
      "invert":    return KIND_INVERT;
      "strike":    return KIND_STRIKE;
      "default":   return KIND_DEFAULT;
      "black":     return KIND_BLACK;
      "red":       return KIND_RED;
      "green":     return KIND_GREEN;
      "yellow":    return KIND_YELLOW;
      "blue":      return KIND_BLUE;
      "magenta":   return KIND_MAGENTA;
      "cyan":      return KIND_CYAN;
      "white":     return KIND_WHITE;
      default:     return KIND_ILLEGAL;
    endcase
  endfunction

  function automatic token_t make_token(input logic [4:0] kind, input logic [15:0] start,
                                        input logic [15:0] dep, input logic unbal);
    token_t t;
    t.kind  = kind;
    t.start = start;
    t.depth = dep;
    t.unbal = unbal;
    t.last  = 1'b0;
    return t;
  endfunction

  // Closes the pending identifier, if any. It always carries the depth as it
  // stood before the byte that ended it.
  task automatic end_identifier();
    if (letter_count == 0) return;
    step_tokens.push_back(make_token(keyword_kind(), letters_start, depth, 1'b0));
    letter_count = 0;
  endtask

  // Works out the token words one accepted byte gives and queues them.
  task automatic lex_byte(input logic [7:0] ch);
    logic [15:0] p;
    logic [4:0]  kind;
    logic        shows;
    logic        unbal;
    p     = char_pos;
    kind  = KIND_ILLEGAL;
    shows = 1'b1;
    unbal = 1'b0;
    step_tokens.delete();
    if (ch == CH_NUL) begin
      // End of string: pending identifier, then EOF, then back to the
      // reset state. The NUL itself takes no position.
      end_identifier();
      step_tokens.push_back(make_token(KIND_EOF, p, depth, 1'b0));
      letter_count  = 0;
      letters_start = '0;
      char_pos      = '0;
      depth         = '0;
      strings_ended++;
    end else begin
      char_pos = p + 16'd1;
      if (is_letter(ch)) begin
        // A full buffer is flushed and the new letter opens a fresh word.
        if (letter_count >= MAX_LETTERS) begin
          end_identifier();
          splits++;
        end
        if (letter_count == 0) letters_start = p;
        letters[letter_count] = ch;
        letter_count++;
      end else begin
        end_identifier();
        case (ch)
          CH_LT:     kind = KIND_LT;
          CH_GT:     kind = KIND_GT;
          CH_LBRACE: kind = KIND_LBRACE;
          CH_RBRACE: kind = KIND_RBRACE;
          CH_COLON:  kind = KIND_COLON;
          CH_COMMA:  kind = KIND_COMMA;
          CH_SLASH:  kind = KIND_SLASH;
          CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: shows = 1'b0;
          default:   kind = KIND_ILLEGAL;
        endcase
        if (shows && (kind == KIND_LT || kind == KIND_LBRACE)) begin
          if (depth != DEPTH_MAX) depth++;
        end else if (kind == KIND_GT || kind == KIND_RBRACE) begin
          // A close at depth zero leaves the depth alone and raises the flag.
          if (depth == 0) begin
            unbal = 1'b1;
            unbal_closes++;
          end else begin
            depth--;
          end
        end
        if (shows) step_tokens.push_back(make_token(kind, p, depth, unbal));
      end
    end
    if (depth > peak_depth) peak_depth = depth;
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
  endtask

  // ------------------------------------------------------------------
  // Driver. At each edge where the current byte has been taken, or nothing
  // is on offer, the next byte may be offered unless the sender idles this
  // cycle. The predictor is fed at the very edge that accepts a byte.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      char_ch.valid     <= 1'b0;
      char_ch.char_byte <= 8'h00;
    end else if (!char_ch.valid || char_ch.ready) begin
      if (char_ch.valid) begin
        lex_byte(char_ch.char_byte);
        bytes_taken++;
      end
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        char_ch.valid     <= 1'b1;
        char_ch.char_byte <= pending_bytes.pop_front();
      end else begin
        char_ch.valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor and receiver. Each accepted token word is checked against the
  // oldest expectation; ready is then chosen for the next edge, either by
  // the random stall rate or by a long hold-off counted down here.
  // ------------------------------------------------------------------
  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= SHOW_LIMIT) $display("%0t ns  mismatch: %s", $time, what);
  endtask

  task automatic check_token();
    token_t want;
    if (tokens_due.size() == 0) begin
      note_mismatch($sformatf("token word kind %0d start %0d with nothing expected",
                              tok_ch.token_kind, tok_ch.token_start));
      return;
    end
    want = tokens_due.pop_front();
    tokens_checked++;
    if (tok_ch.token_kind !== want.kind)
      note_mismatch($sformatf("token %0d kind %0d, expected %0d",
                              tokens_checked, tok_ch.token_kind, want.kind));
    if (tok_ch.token_start !== want.start)
      note_mismatch($sformatf("token %0d start %0d, expected %0d",
                              tokens_checked, tok_ch.token_start, want.start));
    if (tok_ch.bracket_depth_out !== want.depth)
      note_mismatch($sformatf("token %0d depth %0d, expected %0d",
                              tokens_checked, tok_ch.bracket_depth_out, want.depth));
    if (tok_ch.unbalanced_close !== want.unbal)
      note_mismatch($sformatf("token %0d unbalanced flag %0b, expected %0b",
                              tokens_checked, tok_ch.unbalanced_close, want.unbal));
    if (tok_ch.last_of_run !== want.last)
      note_mismatch($sformatf("token %0d last flag %0b, expected %0b",
                              tokens_checked, tok_ch.last_of_run, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tok_ch.ready <= 1'b0;
    end else begin
      if (tok_ch.valid && tok_ch.ready) check_token();
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        tok_ch.ready <= 1'b0;
      end else begin
        tok_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ------------------------------------------------------------------
  // Watchdog: counts edges with no handshake on either channel.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((char_ch.valid && char_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("watchdog: %0d cycles without a handshake, %0d token words still due",
                   quiet, tokens_due.size());
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus. All changes to shared state are made on the falling edge so
  // that the clocked processes see them cleanly at the next rising edge.
  // ------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_total++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s.getc(i));
  endtask

  function automatic logic [7:0] random_letter();
    if ($urandom_range(1) == 0) return 8'(CH_UPPER_A + $urandom_range(25));
    return 8'(CH_LOWER_A + $urandom_range(25));
  endfunction

  // What usually follows a word: mostly blanks or punctuation, rarely a NUL.
  function automatic logic [7:0] separator();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return blanks[$urandom_range(5)];
    if (pick < 95) return punct[$urandom_range(6)];
    return CH_NUL;
  endfunction

  // Waits until every queued byte is taken and every token word has come.
  task automatic drain_all();
    while (pending_bytes.size() != 0 || char_ch.valid || tokens_due.size() != 0)
      @(negedge clk);
  endtask

  // Random text: keywords with near misses, punctuation, blanks, short and long
  // identifiers, nesting, stray bytes and string ends mixed in.
  task automatic add_random(input int n);
    int    target;
    int    pick;
    int    len;
    int    idx;
    string s;
    target = queued_total + n;
    while (queued_total < target) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        s = keywords[$urandom_range(18)];
        case ($urandom_range(9))
          0: begin
            // One letter with its case flipped: matching is case-sensitive.
            idx = $urandom_range(s.len() - 1);
            s.putc(idx, s.getc(idx) ^ 8'h20);
          end
          1: s = s.substr(0, s.len() - 2);
          2: s = {s, "e"};
          default: ;
        endcase
        push_text(s);
        if ($urandom_range(9) < 7) push_byte(separator());
      end else if (pick < 50) begin
        push_byte(punct[$urandom_range(6)]);
      end else if (pick < 60) begin
        push_byte(blanks[$urandom_range(5)]);
      end else if (pick < 70) begin
        len = $urandom_range(1, 8);
        repeat (len) push_byte(random_letter());
      end else if (pick < 75) begin
        // Around and beyond the identifier buffer, so that words get split.
        len = long_lengths[$urandom_range(7)];
        repeat (len) push_byte(random_letter());
        push_byte(separator());
      end else if (pick < 85) begin
        // A nest of opens with keywords inside, closed one short, exactly or
        // one too many.
        len = $urandom_range(1, 5);
        repeat (len) begin
          push_byte(($urandom_range(1) == 0) ? CH_LT : CH_LBRACE);
          if ($urandom_range(1) == 0) push_text(keywords[$urandom_range(18)]);
        end
        repeat (len - 1 + $urandom_range(2)) begin
          push_byte(($urandom_range(1) == 0) ? CH_GT : CH_RBRACE);
        end
      end else if (pick < 93) begin
        push_byte(8'($urandom_range(1, 255)));
      end else if (pick < 97) begin
        push_byte(CH_NUL);
      end else begin
        push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // One traffic phase. The long receiver hold-off, if with_hold is set, starts as the phase opens,
  // while the sender has plenty to offer; half-way through the sender stops
  // until every expected token word is back.
  task automatic run_phase(input int send_pct, input int recv_pct, input int n,
                           input bit with_hold);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_random(n / 2);
    if (with_hold) hold_req = 1'b1;
    drain_all();
    add_random(n - n / 2);
    drain_all();
  endtask

  initial begin
    @(negedge clk);
    while (!rst_n) @(negedge clk);

    // Directed opening: a close at depth zero, a keyword, an illegal word spanning the
    // letter extremes, every punctuation mark, single-letter words, each whitespace
    // byte, stray bytes at both ends of the range and a NUL.
    push_text("}up<Az{x:y,}>/");
    push_byte(CH_TAB);
    push_byte(CH_VT);
    push_byte(CH_FF);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(CH_SPACE);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h01);
    push_byte(CH_NUL);
    drain_all();

    run_phase(21, 49, 550, 1'b1);
    run_phase(49, 21, 550, 1'b1);
    run_phase(0, 0, 520, 1'b0);

    // A deeper nest in one unbroken string with a keyword at the bottom,
    // closed once too often before the string end.
    repeat (NEST_OPENS) push_byte(CH_LT);
    push_byte(CH_LBRACE);
    push_text("bold");
    repeat (NEST_OPENS + 2) push_byte(CH_GT);
    push_byte(CH_NUL);
    drain_all();

    repeat (END_SLACK) @(negedge clk);

    $display("Run covered %0d bytes in %0d strings and checked %0d token words.",
             bytes_taken, strings_ended, tokens_checked);
    $display("Long identifiers split %0d times, %0d stray closes, deepest nesting %0d.",
             splits, unbal_closes, peak_depth);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mkt_pkg.sv
rtl/mkt_if.sv
rtl/mkt_lexer.sv
rtl/mkt_token_fifo.sv
rtl/markup_keyword_tokenizer_core.sv
tb/sv/markup_keyword_tokenizer_core_test.sv
